### rtl/itf_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the digit character table of the integer-to-text formatter.
package itf_pkg;

  // Operand and field geometry
  localparam int VALUE_BITS  = 32;
  localparam int WIDTH_LIMIT = 56;
  localparam int CNT_W       = 6;   // width, precision and digit counts
  localparam int POS_W       = 7;   // character positions within one number
  localparam int DIG_W       = 4;   // one digit, any base up to 16
  localparam int BASE_W      = 5;
  localparam int CHAR_W      = 8;

  // Divider: eight quotient bits per cycle
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_W     = DIV_STEPS * DIV_BITS;
  localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // Flag bit positions
  localparam int FL_ZERO   = 0;
  localparam int FL_SIGNED = 1;
  localparam int FL_PLUS   = 2;
  localparam int FL_SPACE  = 3;
  localparam int FL_LEFT   = 4;
  localparam int FL_LOWER  = 5;
  localparam int FL_PREFIX = 6;

  // Base codes
  localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;
  localparam logic [BASE_W-1:0] BASE_BIN = 5'd2;
  localparam logic [BASE_W-1:0] BASE_OCT = 5'd8;
  localparam logic [BASE_W-1:0] BASE_HEX = 5'd16;

  // Characters
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h58;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_LOWER = 8'h20;

  typedef struct packed {
    logic [31:0] value;
    logic [4:0]  base;
    logic [5:0]  width;
    logic [5:0]  precision;
    logic [6:0]  flags;
  } in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
    logic       error;
  } out_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic                  error;
    logic [VALUE_BITS-1:0] magnitude;
    logic [BASE_W-1:0]     base;
    logic [CNT_W-1:0]      width;
    logic [CNT_W-1:0]      precision;
    logic [CHAR_W-1:0]     sign_char;
    logic                  has_sign;
    logic [1:0]            pfx_len;
    logic                  lower;
    logic                  zero;
    logic                  left;
  } desc_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SETUP,
    BK_EMIT
  } back_state_e;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] c;
    case (d)
      4'h0: c = 8'h30;
      4'h1: c = 8'h31;
      4'h2: c = 8'h32;
      4'h3: c = 8'h33;
      4'h4: c = 8'h34;
      4'h5: c = 8'h35;
      4'h6: c = 8'h36;
      4'h7: c = 8'h37;
      4'h8: c = 8'h38;
      4'h9: c = 8'h39;
      4'hA: c = 8'h41;
      4'hB: c = 8'h42;
      4'hC: c = 8'h43;
      4'hD: c = 8'h44;
      4'hE: c = 8'h45;
      default: c = 8'h46;
    endcase
    return c;
  endfunction

endpackage

### rtl/itf_front.sv
`timescale 1ns / 1ps
// Front end: classify an incoming number into sign, magnitude, prefix and padding choices.
module itf_front import itf_pkg::*; (
  input  in_t   item_i,
  output desc_t desc_o
);

  logic [VALUE_BITS-1:0] v;
  logic                  neg;
  logic                  sgn;

  always_comb begin
    v   = item_i.value[VALUE_BITS-1:0];
    sgn = item_i.flags[FL_SIGNED];
    neg = sgn & v[VALUE_BITS-1];

    desc_o.error     = (item_i.base < BASE_MIN) || (item_i.base > BASE_MAX);
    desc_o.magnitude = neg ? (~v + VALUE_BITS'(1)) : v;
    desc_o.base      = item_i.base;
    desc_o.width     = (item_i.width > CNT_W'(WIDTH_LIMIT)) ? CNT_W'(WIDTH_LIMIT)
                                                            : item_i.width;
    desc_o.precision = (item_i.precision > CNT_W'(WIDTH_LIMIT)) ? CNT_W'(WIDTH_LIMIT)
                                                                : item_i.precision;

    // Plus wins over space; both only for signed conversions
    if (neg) begin
      desc_o.sign_char = CH_MINUS;
    end else if (sgn && item_i.flags[FL_PLUS]) begin
      desc_o.sign_char = CH_PLUS;
    end else begin
      desc_o.sign_char = CH_SPACE;
    end
    desc_o.has_sign = neg || (sgn && (item_i.flags[FL_PLUS] || item_i.flags[FL_SPACE]));

    if (!item_i.flags[FL_PREFIX]) begin
      desc_o.pfx_len = 2'd0;
    end else if (item_i.base == BASE_HEX) begin
      desc_o.pfx_len = 2'd2;
    end else if (item_i.base == BASE_OCT) begin
      desc_o.pfx_len = 2'd1;
    end else begin
      desc_o.pfx_len = 2'd0;
    end

    desc_o.lower = item_i.flags[FL_LOWER];
    desc_o.left  = item_i.flags[FL_LEFT];
    desc_o.zero  = item_i.flags[FL_ZERO] & ~item_i.flags[FL_LEFT];
  end

endmodule

### rtl/itf_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of classified items between the front and the back.
module itf_queue import itf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output desc_t head_o
);

  desc_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/itf_back.sv
`timescale 1ns / 1ps
// Back end: extract digits by iterative division, then emit one beat per unstalled cycle.
module itf_back import itf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  q_valid_i,
  input  desc_t q_data_i,
  output logic  q_pop_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output out_t  out_data_o
);

  localparam int STACK_W = VALUE_BITS * DIG_W;

  back_state_e state_q, state_d;

  desc_t                desc_q;
  logic [DIV_W-1:0]     work_q;
  logic [BASE_W-1:0]    rem_q;
  logic [STEP_W-1:0]    step_q;
  logic [CNT_W-1:0]     dc_q;
  logic [STACK_W-1:0]   stack_q;
  logic [CNT_W-1:0]     left_q;
  logic                 comma_q;
  logic [POS_W-1:0]     pos_q;
  logic [POS_W-1:0]     b1_q, b2_q, b3_q, b5_q, b6_q, total_q;
  logic                 out_valid_q;
  out_t                 out_q;

  logic load_item, do_div, do_setup, fire;

  // Divider datapath
  logic [BASE_W-1:0]   r_div;
  logic [DIV_BITS-1:0] q_bits;
  logic [DIV_W-1:0]    work_div;
  logic                step_last;

  always_comb begin
    r_div = rem_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      r_div = {r_div[BASE_W-2:0], work_q[DIV_W-1-i]};
      if (r_div >= desc_q.base) begin
        r_div             = r_div - desc_q.base;
        q_bits[DIV_BITS-1-i] = 1'b1;
      end else begin
        q_bits[DIV_BITS-1-i] = 1'b0;
      end
    end
    work_div  = {work_q[DIV_W-DIV_BITS-1:0], q_bits};
    step_last = (step_q == STEP_W'(DIV_STEPS - 1));
  end

  // Layout of the text as position boundaries
  logic [CNT_W-1:0] prec, padn, commas, lead_n, zpad_n, tail_n, precz_n;
  logic [7:0]       size;

  always_comb begin
    prec    = (desc_q.precision > dc_q) ? desc_q.precision : dc_q;
    size    = 8'(desc_q.width) - 8'(desc_q.has_sign) - 8'(desc_q.pfx_len) - 8'(prec);
    padn    = size[7] ? '0 : size[CNT_W-1:0];
    lead_n  = (!desc_q.left && !desc_q.zero) ? padn : '0;
    zpad_n  = (!desc_q.left && desc_q.zero) ? padn : '0;
    tail_n  = desc_q.left ? padn : '0;
    precz_n = prec - dc_q;
    commas  = (desc_q.base == BASE_BIN) ? ((dc_q - CNT_W'(1)) >> 3) : '0;
  end

  // Character selection
  logic [CHAR_W-1:0] lower_mask, ch;
  logic              in_digits, is_comma, is_last;

  always_comb begin
    lower_mask = desc_q.lower ? CH_LOWER : CH_NUL;
    in_digits  = 1'b0;
    is_comma   = 1'b0;
    if (pos_q < b1_q) begin
      ch = CH_SPACE;
    end else if (pos_q < b2_q) begin
      ch = desc_q.sign_char;
    end else if (pos_q < b3_q) begin
      ch = (pos_q == b2_q) ? CH_ZERO : (CH_X | lower_mask);
    end else if (pos_q < b5_q) begin
      // zero padding and precision zeros print the same character
      ch = CH_ZERO;
    end else if (pos_q < b6_q) begin
      in_digits = 1'b1;
      is_comma  = (desc_q.base == BASE_BIN) && (left_q[2:0] == 3'd0) &&
                  (left_q != dc_q) && !comma_q;
      ch = is_comma ? CH_COMMA : (hex_char(stack_q[DIG_W-1:0]) | lower_mask);
    end else begin
      ch = CH_SPACE;
    end
    if (desc_q.error) begin
      ch = CH_NUL;
    end
    is_last = ((pos_q + POS_W'(1)) == total_q);
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    q_pop_o   = 1'b0;
    load_item = 1'b0;
    do_div    = 1'b0;
    do_setup  = 1'b0;
    fire      = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o   = 1'b1;
          load_item = 1'b1;
          state_d   = q_data_i.error ? BK_EMIT : BK_DIV;
        end
      end
      BK_DIV: begin
        do_div = 1'b1;
        if (step_last && (work_div == '0)) begin
          state_d = BK_SETUP;
        end
      end
      BK_SETUP: begin
        do_setup = 1'b1;
        state_d  = BK_EMIT;
      end
      BK_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          fire = 1'b1;
          if (is_last) begin
            state_d = BK_IDLE;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      dc_q        <= '0;
      pos_q       <= '0;
      total_q     <= '0;
      left_q      <= '0;
      comma_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_item) begin
        step_q  <= '0;
        dc_q    <= '0;
        pos_q   <= '0;
        total_q <= POS_W'(1);
      end
      if (do_div) begin
        step_q <= step_last ? '0 : step_q + STEP_W'(1);
        if (step_last) begin
          dc_q <= dc_q + CNT_W'(1);
        end
      end
      if (do_setup) begin
        pos_q   <= '0;
        left_q  <= dc_q;
        comma_q <= 1'b0;
        total_q <= POS_W'(lead_n) + POS_W'(desc_q.has_sign) + POS_W'(desc_q.pfx_len) +
                   POS_W'(zpad_n) + POS_W'(precz_n) + POS_W'(dc_q) + POS_W'(commas) +
                   POS_W'(tail_n);
      end
      if (fire) begin
        pos_q <= pos_q + POS_W'(1);
        if (is_comma) begin
          comma_q <= 1'b1;
        end else if (in_digits) begin
          comma_q <= 1'b0;
          left_q  <= left_q - CNT_W'(1);
        end
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (load_item) begin
      desc_q <= q_data_i;
      work_q <= DIV_W'(q_data_i.magnitude);
      rem_q  <= '0;
    end
    if (do_div) begin
      work_q <= work_div;
      rem_q  <= step_last ? '0 : r_div;
      if (step_last) begin
        // Push: the most significant digit so far sits in the low nibble
        stack_q <= {stack_q[STACK_W-DIG_W-1:0], r_div[DIG_W-1:0]};
      end
    end
    if (do_setup) begin
      b1_q <= POS_W'(lead_n);
      b2_q <= POS_W'(lead_n) + POS_W'(desc_q.has_sign);
      b3_q <= POS_W'(lead_n) + POS_W'(desc_q.has_sign) + POS_W'(desc_q.pfx_len);
      b5_q <= POS_W'(lead_n) + POS_W'(desc_q.has_sign) + POS_W'(desc_q.pfx_len) +
              POS_W'(zpad_n) + POS_W'(precz_n);
      b6_q <= POS_W'(lead_n) + POS_W'(desc_q.has_sign) + POS_W'(desc_q.pfx_len) +
              POS_W'(zpad_n) + POS_W'(precz_n) + POS_W'(dc_q) + POS_W'(commas);
    end
    if (fire) begin
      out_q.char_out <= ch;
      out_q.last     <= is_last;
      out_q.error    <= desc_q.error;
      if (in_digits && !is_comma) begin
        stack_q <= {{DIG_W{1'b0}}, stack_q[STACK_W-1:DIG_W]};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/integer_to_text_formatter.sv
`timescale 1ns / 1ps
// Top level of the printf-style integer-to-text formatter.
//
// Each input beat carries one integer with its base (2 to 16), minimum field width,
// precision and flags (zero pad, signed, plus, space, left justify, lower case, prefix);
// the block answers with the formatted text, one ASCII character per output beat, with
// last set on the final character. A base outside 2 to 16 yields a single beat with
// char_out 0, last 1 and error 1. In base 2 a comma separates each group of eight digits,
// and commas do not count against the width; width and precision saturate at 56.
// A front end classifies each beat (sign, magnitude, prefix, padding kind) and drops it
// into a two-entry queue, so the input keeps flowing while the back end is busy, until
// both entries are taken. The back end takes one queued number at a time: it divides the
// magnitude by the base with a divider that resolves eight quotient bits per cycle, one
// digit per full division, then lays out the field in a setup state and emits one
// character per cycle while the output side does not stall. Output beats come from a
// register, so the back end can take and divide the next number while the last character
// of the previous one waits to be taken.
module integer_to_text_formatter import itf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  desc_t front_desc;
  desc_t head_desc;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;
  logic  in_fire;

  // Hold off the source only when both queue slots are taken
  assign in_stall_o = q_full;
  assign in_fire    = in_valid_i && !q_full;

  itf_front u_front (
    .item_i (in_data_i),
    .desc_o (front_desc)
  );

  itf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire),
    .push_data_i (front_desc),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (head_desc)
  );

  itf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (head_desc),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### tb/integer_to_text_formatter_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the integer-to-text formatter with its own text predictor.
module integer_to_text_formatter_test;
  import itf_pkg::*;

  // Flag masks built from the package bit positions
  localparam logic [6:0] F_ZERO   = 7'(1 << FL_ZERO);
  localparam logic [6:0] F_SIGNED = 7'(1 << FL_SIGNED);
  localparam logic [6:0] F_PLUS   = 7'(1 << FL_PLUS);
  localparam logic [6:0] F_SPACE  = 7'(1 << FL_SPACE);
  localparam logic [6:0] F_LEFT   = 7'(1 << FL_LEFT);
  localparam logic [6:0] F_LOWER  = 7'(1 << FL_LOWER);
  localparam logic [6:0] F_PREFIX = 7'(1 << FL_PREFIX);

  localparam logic [CHAR_W-1:0] CH_DIGIT_A = 8'h41;  // first letter digit
  localparam int RANDOM_NUMBERS = 380;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 300;

  typedef enum logic [2:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HALF,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  // One queued number, optionally held back until all earlier text has come out
  typedef struct {
    in_t beat;
    bit  drain_first;
  } pending_number_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  pending_number_t pending_numbers[$];
  out_t            expected_chars[$];
  pending_number_t next_number;
  out_t            want;

  bit          in_taken        = 1'b0;
  int          numbers_sent    = 0;
  int          invalid_bases   = 0;
  int          chars_checked   = 0;
  int          mismatches      = 0;
  int          in_stall_cycles = 0;
  int          burst_left      = 0;
  int          gap_left        = 0;
  int          hold_left       = 0;
  int          holds_done      = 0;
  int          mode_left       = 0;
  stall_mode_e stall_mode      = STALL_NONE;
  int          hold_points[2]  = '{60, 250};

  integer_to_text_formatter DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Predict the full printf-style text of one number and queue it, one character per
  // beat, last on the final character. Layout: space padding, sign, prefix, zero or
  // space padding, precision zeros, digits (commas every eight in base 2), trailing
  // spaces when left-justified.
  function automatic void format_number(input in_t beat);
    logic [VALUE_BITS-1:0] mag;
    logic [BASE_W-1:0]     radix;
    logic [6:0]            fl;
    logic [CHAR_W-1:0]     sign_ch;
    logic [CHAR_W-1:0]     pad_ch;
    logic [CHAR_W-1:0]     case_bit;
    logic [CHAR_W-1:0]     digit_ch;
    logic [DIG_W-1:0]      digs[32];
    logic [CHAR_W-1:0]     text[$];
    int                    field_w;
    int                    min_digits;
    int                    ndig;
    int                    grp;
    int                    room;
    radix      = beat.base;
    fl         = beat.flags;
    field_w    = (beat.width > WIDTH_LIMIT) ? WIDTH_LIMIT : int'(beat.width);
    min_digits = (beat.precision > WIDTH_LIMIT) ? WIDTH_LIMIT : int'(beat.precision);
    // left justification overrides zero padding
    if (fl[FL_LEFT]) fl[FL_ZERO] = 1'b0;
    case_bit = fl[FL_LOWER] ? CH_LOWER : 8'h00;

    if (radix < BASE_MIN || radix > BASE_MAX) begin
      expected_chars.push_back('{char_out: CH_NUL, last: 1'b1, error: 1'b1});
      return;
    end

    pad_ch  = fl[FL_ZERO] ? CH_ZERO : CH_SPACE;
    room    = field_w;
    mag     = beat.value;
    sign_ch = CH_NUL;
    // plus and space only count for signed conversion; plus wins over space
    if (fl[FL_SIGNED]) begin
      if (beat.value[VALUE_BITS-1]) begin
        mag     = -beat.value;
        sign_ch = CH_MINUS;
      end else if (fl[FL_PLUS]) begin
        sign_ch = CH_PLUS;
      end else if (fl[FL_SPACE]) begin
        sign_ch = CH_SPACE;
      end
    end
    if (sign_ch != CH_NUL) room--;
    if (fl[FL_PREFIX]) begin
      if (radix == BASE_HEX) room -= 2;
      else if (radix == BASE_OCT) room--;
    end

    ndig = 0;
    do begin
      digs[ndig] = DIG_W'(mag % radix);
      ndig++;
      mag = mag / radix;
    end while (mag != 0 && ndig < 32);

    if (min_digits < ndig) min_digits = ndig;
    room -= min_digits;

    if (!fl[FL_ZERO] && !fl[FL_LEFT]) begin
      while (room > 0) begin
        text.push_back(CH_SPACE);
        room--;
      end
    end
    if (sign_ch != CH_NUL) text.push_back(sign_ch);
    if (fl[FL_PREFIX] && (radix == BASE_OCT || radix == BASE_HEX)) begin
      text.push_back(CH_ZERO);
      if (radix == BASE_HEX) text.push_back(CH_X | case_bit);
    end
    if (!fl[FL_LEFT]) begin
      while (room > 0) begin
        text.push_back(pad_ch);
        room--;
      end
    end
    repeat (min_digits - ndig) text.push_back(CH_ZERO);

    // commas are counted from the least significant digit
    grp = (radix == BASE_BIN) ? ((8 - (ndig & 7)) & 7) : 0;
    for (int k = ndig; k > 0; k--) begin
      if (radix == BASE_BIN && grp == 8) begin
        text.push_back(CH_COMMA);
        grp = 0;
      end
      digit_ch = (digs[k-1] < 10) ? CH_ZERO + digs[k-1] : CH_DIGIT_A + digs[k-1] - 8'd10;
      text.push_back(digit_ch | case_bit);
      if (radix == BASE_BIN) grp++;
    end
    while (room > 0) begin
      text.push_back(CH_SPACE);
      room--;
    end

    foreach (text[i])
      expected_chars.push_back('{char_out: text[i], last: (i == text.size() - 1), error: 1'b0});
  endfunction

  task automatic add_number(input logic [31:0] value, input logic [4:0] base,
                            input logic [5:0] width, input logic [5:0] precision,
                            input logic [6:0] flags, input bit drain_first);
    pending_numbers.push_back('{beat: '{value: value, base: base, width: width,
                                        precision: precision, flags: flags},
                                drain_first: drain_first});
  endtask

  // Edge sampling: record input acceptance, check each output beat against the oldest
  // expected character, then predict the text of any number taken at this edge.
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected beat char_out=%h last=%b error=%b", $time,
                 out_data_o.char_out, out_data_o.last, out_data_o.error);
        mismatches++;
      end else begin
        want = expected_chars.pop_front();
        if (out_data_o.char_out !== want.char_out) begin
          $display("%0t: char_out expected %h actual %h", $time, want.char_out,
                   out_data_o.char_out);
          mismatches++;
        end
        if (out_data_o.last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, out_data_o.last);
          mismatches++;
        end
        if (out_data_o.error !== want.error) begin
          $display("%0t: error expected %b actual %b", $time, want.error, out_data_o.error);
          mismatches++;
        end
        chars_checked++;
      end
    end
    if (in_taken) begin
      format_number(in_data_i);
      numbers_sent++;
      if (in_data_i.base < BASE_MIN || in_data_i.base > BASE_MAX) invalid_bases++;
    end
    if (rst_ni && in_valid_i && in_stall_o) in_stall_cycles++;
  end

  // Input driver: hold a stalled beat, otherwise send in bursts separated by random
  // gaps. A number marked drain_first waits until every earlier character is out.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_taken) begin
      // hold the beat until it is accepted
    end else if (gap_left != 0) begin
      in_valid_i <= 1'b0;
      gap_left--;
    end else if (pending_numbers.size() == 0 ||
                 (pending_numbers[0].drain_first && expected_chars.size() != 0)) begin
      in_valid_i <= 1'b0;
    end else begin
      next_number = pending_numbers.pop_front();
      in_data_i  <= next_number.beat;
      in_valid_i <= 1'b1;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        // a quarter of the bursts follow on without any gap
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end
  end

  // Output receiver: switch among random stall patterns, and twice hold off for a long
  // stretch so the block backs up into its input.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (holds_done < 2 && numbers_sent >= hold_points[holds_done]) begin
      out_stall_i <= 1'b1;
      hold_left  = HOLD_CYCLES - 1;
      holds_done++;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 4));
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HALF:  out_stall_i <= 1'($urandom_range(0, 1));
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:     out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  // Stimulus, reset and end of run
  initial begin
    logic [31:0] rvalue;
    logic [4:0]  rbase;
    logic [5:0]  rwidth;
    logic [5:0]  rprec;

    // directed numbers
    add_number(32'd0,          5'd10, 6'd0,  6'd0,  7'd0, 1'b0);       // zero, precision 0
    add_number(32'd0,          5'd16, 6'd0,  6'd0,  F_PREFIX, 1'b0);
    add_number(32'hFFFF_FFFF,  5'd16, 6'd0,  6'd0,  7'd0, 1'b0);
    add_number(32'hDEAD_BEEF,  5'd16, 6'd14, 6'd0,  F_PREFIX | F_LOWER | F_ZERO, 1'b0);
    add_number(32'h8000_0000,  5'd10, 6'd0,  6'd0,  F_SIGNED, 1'b0);   // most negative
    add_number(32'hFFFF_FFFB,  5'd10, 6'd6,  6'd0,  F_SIGNED | F_PLUS, 1'b0);
    add_number(32'd42,         5'd10, 6'd6,  6'd0,  F_SIGNED | F_PLUS, 1'b0);
    add_number(32'd42,         5'd10, 6'd6,  6'd0,  F_SIGNED | F_SPACE, 1'b0);
    add_number(32'd42,         5'd10, 6'd6,  6'd0,  F_SIGNED | F_PLUS | F_SPACE, 1'b0);
    add_number(32'd42,         5'd10, 6'd6,  6'd0,  F_PLUS | F_SPACE, 1'b0); // unsigned
    add_number(32'd511,        5'd8,  6'd0,  6'd0,  F_PREFIX, 1'b0);
    add_number(32'd255,        5'd10, 6'd0,  6'd0,  F_PREFIX, 1'b0);
    add_number(32'd255,        5'd2,  6'd0,  6'd0,  F_PREFIX, 1'b0);   // eight binary digits
    add_number(32'hFFFF_FFFF,  5'd2,  6'd0,  6'd0,  7'd0, 1'b0);       // 32 digits, commas
    add_number(32'h0001_2345,  5'd2,  6'd40, 6'd0,  F_ZERO, 1'b0);
    add_number(32'd123,        5'd10, 6'd63, 6'd0,  7'd0, 1'b0);       // width saturates
    add_number(32'd123,        5'd10, 6'd0,  6'd63, 7'd0, 1'b0);       // precision saturates
    add_number(32'd1,          5'd10, 6'd56, 6'd56, F_SIGNED | F_PLUS, 1'b0);
    add_number(32'd77,         5'd10, 6'd10, 6'd0,  F_ZERO | F_LEFT, 1'b0);
    add_number(32'hFFFF_FF85,  5'd16, 6'd12, 6'd8,
               F_SIGNED | F_ZERO | F_PREFIX | F_LOWER, 1'b0);
    add_number(32'd99,         5'd0,  6'd0,  6'd0,  7'd0, 1'b0);       // invalid bases
    add_number(32'd99,         5'd1,  6'd5,  6'd0,  7'd0, 1'b0);
    add_number(32'd99,         5'd17, 6'd0,  6'd3,  7'd0, 1'b0);
    add_number(32'hFFFF_FFFF,  5'd31, 6'd63, 6'd63, 7'h7F, 1'b0);
    add_number(32'h7FFF_FFFF,  5'd5,  6'd20, 6'd0,  F_LEFT | F_SIGNED | F_SPACE, 1'b0);

    // random numbers, mostly valid bases with short to medium fields
    for (int n = 0; n < RANDOM_NUMBERS; n++) begin
      case ($urandom_range(0, 5))
        0:       rvalue = $urandom;
        1:       rvalue = $urandom_range(0, 15);
        2:       rvalue = $urandom_range(0, 999);
        3:       rvalue = $urandom >> $urandom_range(0, 31);
        4:       rvalue = -$urandom_range(1, 1000);
        default: begin
          case ($urandom_range(0, 3))
            0:       rvalue = 32'h8000_0000;
            1:       rvalue = 32'hFFFF_FFFF;
            2:       rvalue = 32'h7FFF_FFFF;
            default: rvalue = 32'd0;
          endcase
        end
      endcase
      if ($urandom_range(0, 9) == 0) rbase = 5'($urandom_range(0, 31));
      else if ($urandom_range(0, 2) == 0) rbase = 5'(5'd2 << $urandom_range(0, 3));
      else if ($urandom_range(0, 3) == 0) rbase = 5'd10;
      else rbase = 5'($urandom_range(2, 16));
      rwidth = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, 20));
      rprec  = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, 12));
      add_number(rvalue, rbase, rwidth, rprec, 7'($urandom_range(0, 127)), (n % 50) == 0);
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // drain: all numbers accepted and all text returned, then watch for stray beats
    do @(negedge clk_i);
    while (pending_numbers.size() != 0 || in_valid_i || expected_chars.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Formatted %0d numbers (%0d with an invalid base), checked %0d characters.",
             numbers_sent, invalid_bases, chars_checked);
    $display("Input held off for %0d cycles under output backpressure.", in_stall_cycles);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run
  initial begin
    #(64'd10_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
rtl/itf_pkg.sv
rtl/itf_front.sv
rtl/itf_queue.sv
rtl/itf_back.sv
rtl/integer_to_text_formatter.sv
tb/integer_to_text_formatter_test.sv
